// ===== hdl/sft_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sft_pkg
// Shared types and constants for the semiprime factor / totient block.
// ---------------------------------------------------------------------------
package sft_pkg;

    localparam int NUMBER_WIDTH_DEF = 31;

    // controller -> datapath
    typedef struct packed {
        logic load;          // capture the input number, reset trial divisor
        logic take_invalid;  // result: input below two
        logic take_even;     // result: factor two
        logic take_prime;    // result: no divisor up to the square root
        logic take_found;    // result: current divisor divides evenly
        logic next_s;        // advance trial divisor by two
        logic div_start;     // launch a division of n by the trial divisor
        logic out_load;      // move result into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic lt2;       // number is 0 or 1
        logic even;      // number is even
        logic div_done;  // divider finishes this cycle
        logic q_lt_s;    // quotient below trial divisor: search exhausted
        logic rem_zero;  // remainder zero
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hdl/sft_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sft_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module sft_div #(
    parameter int W = 31
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quotient,
    output logic [W-1:0]      o_remainder
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_dvs, n_dvs;

    logic [W:0]    rem_shift;
    logic [W:0]    diff;

    assign rem_shift = {r_rem, r_quo[W-1]};
    assign diff      = rem_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the top bit drops out
            if (!diff[W]) begin
                n_rem = diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = rem_shift[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_busy && (r_cnt == '0);
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

// ===== hdl/sft_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sft_datapath
// Number and trial divisor registers, divider, result and output registers.
// ---------------------------------------------------------------------------
module sft_datapath
    import sft_pkg::*;
#(
    parameter int W = NUMBER_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_dp_cmd      i_cmd,
    output t_dp_sts           o_sts,
    input  wire logic [W-1:0] i_number,
    output logic [W-1:0]      o_larger_factor,
    output logic [W-1:0]      o_smaller_factor,
    output logic [W-1:0]      o_coprime_count,
    output logic              o_status
);
    localparam int WX = W + 1;

    logic [W-1:0] r_n, n_n;
    logic [W-1:0] r_s, n_s;
    logic [W-1:0] r_big, n_big;
    logic [W-1:0] r_small, n_small;
    logic         r_inval, n_inval;

    logic [W-1:0] r_o_big, r_o_small, r_o_count;
    logic         r_o_status;

    logic         div_done;
    logic [W-1:0] quo, rem;
    logic [WX-1:0] fsum;
    logic [W-1:0]  count;

    sft_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_n),
        .i_divisor  (r_s),
        .o_done     (div_done),
        .o_quotient (quo),
        .o_remainder(rem)
    );

    always_comb begin
        n_n     = r_n;
        n_s     = r_s;
        n_big   = r_big;
        n_small = r_small;
        n_inval = r_inval;
        if (i_cmd.load) begin
            n_n = i_number;
            n_s = W'(3);
        end
        if (i_cmd.next_s) begin
            n_s = r_s + W'(2);
        end
        if (i_cmd.take_invalid) begin
            n_big   = '0;
            n_small = '0;
            n_inval = 1'b1;
        end
        if (i_cmd.take_even) begin
            n_big   = {1'b0, r_n[W-1:1]};
            n_small = W'(2);
            n_inval = 1'b0;
        end
        if (i_cmd.take_prime) begin
            n_big   = W'(1);
            n_small = r_n;
            n_inval = 1'b0;
        end
        if (i_cmd.take_found) begin
            n_big   = quo;
            n_small = r_s;
            n_inval = 1'b0;
        end
    end

    // n - (big + small - 1); zero for the invalid case
    assign fsum  = {1'b0, r_big} + {1'b0, r_small};
    assign count = r_inval ? '0 : W'({1'b0, r_n} - fsum + WX'(1));

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_s     <= n_s;
        r_big   <= n_big;
        r_small <= n_small;
        r_inval <= n_inval;
        if (i_cmd.out_load) begin
            r_o_big    <= r_big;
            r_o_small  <= r_small;
            r_o_count  <= count;
            r_o_status <= r_inval;
        end
    end

    assign o_sts.lt2      = (r_n[W-1:1] == '0);
    assign o_sts.even     = ~r_n[0];
    assign o_sts.div_done = div_done;
    assign o_sts.q_lt_s   = (quo < r_s);
    assign o_sts.rem_zero = (rem == '0);

    assign o_larger_factor  = r_o_big;
    assign o_smaller_factor = r_o_small;
    assign o_coprime_count  = r_o_count;
    assign o_status         = r_o_status;

endmodule
`default_nettype wire

// ===== hdl/sft_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sft_ctrl
// Sequencer for the trial division search and the output handshake.
// ---------------------------------------------------------------------------
module sft_ctrl
    import sft_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.lt2) begin
                    o_cmd.take_invalid = 1'b1;
                    n_state            = S_FIN;
                end else if (i_sts.even) begin
                    o_cmd.take_even = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // divisor past the square root: number is prime
                if (i_sts.q_lt_s) begin
                    o_cmd.take_prime = 1'b1;
                    n_state          = S_FIN;
                end else if (i_sts.rem_zero) begin
                    o_cmd.take_found = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.next_s = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hdl/semiprime_factor_totient.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// semiprime_factor_totient
// Factors a number by trial division and returns both factors and
// n - (larger + smaller - 1): totient when both factors are distinct primes.
//
//   beat     direction  handshake          payload
//   input    in         i_valid/o_ready    i_number
//   result   out        o_valid/i_ready    o_larger_factor, o_smaller_factor,
//                                          o_coprime_count, o_status
//
// Inputs below two and even inputs are decided in the classify state.
// Odd inputs run one division per odd trial divisor s = 3, 5, ...; each trial
// runs the bit-serial divider and then an evaluate step, and the search
// ends at the least factor or once s passes sqrt(number).
// Reset clears the sequencer and output valid; data registers are not reset.
// A new input is taken while a result still waits in the output register;
// the block stalls at the end of that item until the result is taken.
// ---------------------------------------------------------------------------
module semiprime_factor_totient
    import sft_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [NUMBER_WIDTH-1:0] i_number,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [NUMBER_WIDTH-1:0]      o_larger_factor,
    output logic [NUMBER_WIDTH-1:0]      o_smaller_factor,
    output logic [NUMBER_WIDTH-1:0]      o_coprime_count,
    output logic                         o_status
);
    t_dp_cmd cmd;
    t_dp_sts sts;

    sft_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_cmd  (cmd),
        .i_sts  (sts)
    );

    sft_datapath #(.W(NUMBER_WIDTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_number        (i_number),
        .o_larger_factor (o_larger_factor),
        .o_smaller_factor(o_smaller_factor),
        .o_coprime_count (o_coprime_count),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for semiprime_factor_totient: numbers go in over a
// valid/ready channel, each result beat is checked against a predicted
// factor pair, coprime count and status, under three idle profiles.
// ---------------------------------------------------------------------------
module tb;

    localparam int NW = sft_pkg::NUMBER_WIDTH_DEF;
    localparam longint unsigned NUM_MAX = (64'd1 << NW) - 64'd1;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int STALL_LIMIT = 300000;
    localparam int SLOW_FACTOR_CAP = 1024;

    // Holds the factor results still owed by the block, in input order.
    class factor_scoreboard;
        localparam int W = sft_pkg::NUMBER_WIDTH_DEF;

        typedef struct packed {
            logic [W-1:0] larger;
            logic [W-1:0] smaller;
            logic [W-1:0] count;
            logic         status;
        } t_factor_result;

        t_factor_result owed[$];
        int numbers_in;
        int results_checked;
        int errors;

        function new();
            numbers_in = 0;
            results_checked = 0;
            errors = 0;
        endfunction

        // smallest divisor above one; the value itself when prime
        static function longint unsigned smallest_factor(longint unsigned v);
            longint unsigned s;
            if (v % 2 == 0)
                return 2;
            s = 3;
            while (s <= v / s) begin
                if (v % s == 0)
                    return s;
                s += 2;
            end
            return v;
        endfunction

        function t_factor_result predict_factors(logic [W-1:0] n);
            longint unsigned v;
            longint unsigned big;
            longint unsigned sm;
            longint unsigned cnt;
            t_factor_result r;
            v = n;
            if (v < 2) begin
                r.larger = '0;
                r.smaller = '0;
                r.count = '0;
                r.status = 1'b1;
            end else begin
                big = v / smallest_factor(v);
                sm = v / big;
                cnt = v - (big + sm - 1);
                r.larger = big[W-1:0];
                r.smaller = sm[W-1:0];
                r.count = cnt[W-1:0];
                r.status = 1'b0;
            end
            return r;
        endfunction

        function void note_number(logic [W-1:0] n);
            owed.push_back(predict_factors(n));
            numbers_in++;
        endfunction

        function void check_result(logic [W-1:0] larger, logic [W-1:0] smaller,
                                   logic [W-1:0] count, logic status);
            t_factor_result exp_r;
            results_checked++;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("tb: result beat with nothing owed: %0d %0d %0d %0b",
                             larger, smaller, count, status);
                return;
            end
            exp_r = owed.pop_front();
            if (larger !== exp_r.larger || smaller !== exp_r.smaller ||
                count !== exp_r.count || status !== exp_r.status) begin
                errors++;
                if (errors <= 10)
                    $display("tb: mismatch exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                             exp_r.larger, exp_r.smaller, exp_r.count, exp_r.status,
                             larger, smaller, count, status);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic [NW-1:0] i_number = '0;
    logic          i_ready = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic [NW-1:0] o_larger_factor;
    logic [NW-1:0] o_smaller_factor;
    logic [NW-1:0] o_coprime_count;
    logic          o_status;

    int tx_idle_pct = 11;
    int rx_idle_pct = 65;
    int stall_cycles = 0;

    factor_scoreboard sb = new();

    semiprime_factor_totient u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_number        (i_number),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_larger_factor (o_larger_factor),
        .o_smaller_factor(o_smaller_factor),
        .o_coprime_count (o_coprime_count),
        .o_status        (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_larger_factor, o_smaller_factor, o_coprime_count, o_status);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // first prime at or after start (downward: at or before)
    function automatic longint unsigned prime_from(longint unsigned start, bit downward);
        longint unsigned v;
        v = (start < 2) ? 2 : start;
        while (factor_scoreboard::smallest_factor(v) != v)
            v = downward ? v - 1 : v + 1;
        return v;
    endfunction

    // Random numbers: the largest share semiprimes with a small factor so the search
    // stays short; the rest raw values, small values and prime squares.
    function automatic longint unsigned pick_number();
        longint unsigned p;
        longint unsigned q;
        longint unsigned n;
        longint unsigned lim;
        int kind;
        int w;
        kind = $urandom_range(99);
        if (kind < 35 || kind >= 90) begin
            p = (kind < 35) ? prime_from($urandom_range(2, 300), 1'b0)
                            : prime_from($urandom_range(300, 1000), 1'b0);
            lim = NUM_MAX / p;
            do
                q = prime_from($urandom_range(2, lim - 1000), 1'b0);
            while (p * q > NUM_MAX);
            n = p * q;
        end else if (kind < 65) begin
            // raw value of random bit length; skip ones that would search too long
            do begin
                w = $urandom_range(1, NW);
                n = {32'd0, $urandom} & ((64'd1 << w) - 1);
            end while (n >= 2 && n >= (64'd1 << 20) &&
                       factor_scoreboard::smallest_factor(n) > SLOW_FACTOR_CAP);
        end else if (kind < 80) begin
            n = $urandom_range(0, 2000);
        end else begin
            p = prime_from($urandom_range(2, 1000), 1'b0);
            n = p * p;
        end
        return n;
    endfunction

    task automatic send_number(longint unsigned n);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_number <= n[NW-1:0];
        do
            @(posedge i_clk);
        while (!o_ready);
        sb.note_number(n[NW-1:0]);
    endtask

    // hold the input side off until every owed result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        longint unsigned directed[$];
        int phase;
        int i;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // below two, two and three, squares, non-semiprimes, wide bit patterns
        directed = '{0, 1, 2, 3, 4, 5, 9, 15, 21, 30, 105, 121,
                     64'h4000_0000, 64'h7FFF_FFFE, 64'h5555_5555, 64'h2AAA_AAAA};
        directed.push_back(3 * prime_from(715000000, 1'b0));
        directed.push_back(2 * prime_from(1073741000, 1'b0));
        directed.push_back(prime_from((64'd1 << 20) - 1, 1'b1));
        directed.push_back(1009 * 1009);
        directed.push_back(prime_from(4092, 1'b0) * prime_from(4094, 1'b0));

        foreach (directed[k])
            send_number(directed[k]);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 11;
                    rx_idle_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 11;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (i = 0; i < RANDOM_PER_PHASE; i++)
                send_number(pick_number());
            wait_drained();
        end

        repeat (8) @(posedge i_clk);

        $display("tb: %0d numbers factored, %0d result beats checked, %0d mismatches",
                 sb.numbers_in, sb.results_checked, sb.errors);
        $display("tb: inputs below two, primes, prime squares, composites, wide values;"
                 , " three idle profiles");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
